// ===== design/tsdfvu_pkg.sv =====
// Shared widths and stage payload type for the voxel update pipeline.
`timescale 1ns / 1ps

package tsdfvu_pkg;

	localparam int CODE_W = 16;
	localparam int WGT_W  = 8;
	localparam int T_W    = 31;
	localparam int S_W    = 32;
	localparam int A_W    = 26;
	localparam int DW_W   = 10;
	localparam int TA_W   = T_W + A_W;
	localparam int SM_W   = S_W + 18;
	localparam int DEN_W  = T_W + DW_W;
	localparam int NUM_W  = 58;
	localparam int Q_W    = 17;

	localparam logic [T_W-1:0] MARGIN_RESET = T_W'(1024);

	typedef struct packed {
		logic              upd;
		logic [CODE_W-1:0] code;
		logic [WGT_W-1:0]  weight;
	} pass_t;

endpackage

// ===== design/tsdf_voxel_update_core.sv =====
// Voxel update core: clamp, scale, restoring divide and saturate in one pipeline.
// Pipeline from input acceptance to out_valid: 3 front stages, 17 divide stages and
// 1 output register; the restoring divider retires one quotient bit per stage.
// Throughput: one item per cycle while out_ready is high; a held output freezes every stage.
// Reset clears all stage valid bits and loads the stored margin t_q with 1024.
`timescale 1ns / 1ps

module tsdf_voxel_update_core #(
	parameter int unsigned CODE_MAX   = 65535,
	parameter int unsigned WEIGHT_MAX = 255,
	parameter int unsigned DIST_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tsdfvu_pkg::T_W-1:0]   trunc_margin,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tsdfvu_pkg::CODE_W-1:0] old_code,
	input  logic [tsdfvu_pkg::WGT_W-1:0]  old_weight,
	input  logic signed [DIST_BITS-1:0]  new_distance,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tsdfvu_pkg::CODE_W-1:0] new_code,
	output logic [tsdfvu_pkg::WGT_W-1:0]  new_weight,
	output logic                         was_updated
);
	import tsdfvu_pkg::*;

	localparam int CMP_W = ((DIST_BITS > S_W) ? DIST_BITS : S_W) + 1;
	localparam logic signed [17:0] M_SGN = 18'(CODE_MAX);
	localparam logic [16:0] M_P1 = 17'(CODE_MAX + 1);

	logic [T_W-1:0] t_q;
	logic           adv;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= MARGIN_RESET;
		end else if (cfg_valid) begin
			t_q <= (trunc_margin == '0) ? T_W'(1) : trunc_margin;
		end
	end

	// stage 1: clamp sample, form weighted code term
	logic signed [CMP_W-1:0] s_ext, t_ext;
	logic signed [S_W-1:0]   s_clamp, t_pos;
	logic signed [17:0]      twop_m;
	logic signed [26:0]      w_term, a_full;
	logic [8:0]              wp1;
	logic [25:0]             c_term;
	pass_t                   pass_in;

	assign s_ext  = CMP_W'(new_distance);
	assign t_ext  = signed'({{(CMP_W-T_W){1'b0}}, t_q});
	assign t_pos  = signed'({1'b0, t_q});
	assign twop_m = signed'({1'b0, old_code, 1'b0}) - M_SGN;
	assign wp1    = {1'b0, old_weight} + 9'd1;
	assign w_term = signed'({1'b0, old_weight}) * twop_m;
	assign c_term = wp1 * M_P1;
	assign a_full = w_term + signed'({1'b0, c_term});

	always_comb begin
		priority if (s_ext > t_ext) begin
			s_clamp = t_pos;
		end else if (s_ext < -t_ext) begin
			s_clamp = -t_pos;
		end else begin
			s_clamp = s_ext[S_W-1:0];
		end
	end

	always_comb begin
		pass_in.upd    = {8'd0, old_weight} < 16'(WEIGHT_MAX);
		pass_in.code   = old_code;
		pass_in.weight = pass_in.upd ? wp1[WGT_W-1:0] : old_weight;
	end

	logic                  vld_s1;
	logic signed [S_W-1:0] s_s1;
	logic [A_W-1:0]        a_s1;
	logic [DW_W-1:0]       dw_s1;
	pass_t                 pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1    <= s_clamp;
			a_s1    <= a_full[A_W-1:0];
			dw_s1   <= {wp1, 1'b0};
			pass_s1 <= pass_in;
		end
	end

	// stage 2: products
	logic                   vld_s2;
	logic [TA_W-1:0]        ta_s2;
	logic signed [SM_W-1:0] sm_s2;
	logic [DEN_W-1:0]       td_s2;
	pass_t                  pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s2   <= t_q * a_s1;
			sm_s2   <= s_s1 * M_SGN;
			td_s2   <= t_q * dw_s1;
			pass_s2 <= pass_s1;
		end
	end

	// stage 3 and divide stages: index 0 holds numerator and divisor
	logic                   vld_sd  [0:Q_W];
	logic [Q_W-1:0]         quo_sd  [0:Q_W];
	pass_t                  pass_sd [0:Q_W];
	logic [NUM_W-1:0]       rem_sd  [0:Q_W-1];
	logic [DEN_W-1:0]       den_sd  [0:Q_W-1];
	logic signed [NUM_W-1:0] num_sum;

	assign num_sum = signed'({1'b0, ta_s2}) + NUM_W'(sm_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sd[0]  <= unsigned'(num_sum);
			den_sd[0]  <= td_s2;
			quo_sd[0]  <= '0;
			pass_sd[0] <= pass_s2;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_div
		localparam int SH = Q_W - k;
		logic [NUM_W-1:0] sub_den;
		logic             ge;
		logic [Q_W-1:0]   quo_nx;

		assign sub_den = NUM_W'(den_sd[k-1]) << SH;
		assign ge      = rem_sd[k-1] >= sub_den;

		always_comb begin
			quo_nx     = quo_sd[k-1];
			quo_nx[SH] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (adv) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_sd[k]  <= quo_nx;
				pass_sd[k] <= pass_sd[k-1];
			end
		end

		if (k < Q_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_sd[k] <= ge ? (rem_sd[k-1] - sub_den) : rem_sd[k-1];
					den_sd[k] <= den_sd[k-1];
				end
			end
		end
	end

	// output register: saturate or pass the voxel through
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic [WGT_W-1:0]  out_weight_q;
	logic              out_upd_q;
	logic [CODE_W-1:0] code_sat;

	assign code_sat = (quo_sd[Q_W] > Q_W'(CODE_MAX)) ? CODE_W'(CODE_MAX)
		: quo_sd[Q_W][CODE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_sd[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_code_q   <= pass_sd[Q_W].upd ? code_sat : pass_sd[Q_W].code;
			out_weight_q <= pass_sd[Q_W].weight;
			out_upd_q    <= pass_sd[Q_W].upd;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_code    = out_code_q;
	assign new_weight  = out_weight_q;
	assign was_updated = out_upd_q;

`ifndef SYNTH
	a_margin_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		t_q != '0)
		else $error("stored margin is zero");

	a_code_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_updated |-> new_code <= CODE_W'(CODE_MAX))
		else $error("averaged code above code maximum");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sd[Q_W-1] |-> rem_sd[Q_W-1] < (NUM_W'(den_sd[Q_W-1]) << 1))
		else $error("divider remainder out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_sd[0]) && $stable(vld_s1) && $stable(vld_s2))
		else $error("pipeline moved during stall");
`endif

endmodule
